FILE: design/s2a_pkg.sv
// s2a_pkg: shared constants and the set-1 translation tables for the scancode to ascii block
// no dependencies; imported by scancode_to_ascii_fifo
`timescale 1ns / 1ps

package s2a_pkg;

    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;

    localparam int CharW    = 7;
    localparam int TableLen = 58;

    localparam logic [CharW-1:0] PLAIN_MAP [0:TableLen-1] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
        7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72,
        7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00,
        7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E,
        7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    localparam logic [CharW-1:0] UPPER_MAP [0:TableLen-1] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
        7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52,
        7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00,
        7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E,
        7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
    };

    // make code (bit 7 clear) to ascii, zero for keys without a character
    function automatic logic [CharW-1:0] sc_lookup(input logic [6:0] code, input logic shift);
        logic [CharW-1:0] ch;
        ch = '0;
        if (code < 7'(TableLen)) begin
            ch = shift ? UPPER_MAP[code[5:0]] : PLAIN_MAP[code[5:0]];
        end
        return ch;
    endfunction

endpackage

FILE: design/scancode_to_ascii_fifo.sv
// scancode_to_ascii_fifo: set-1 scancode translator feeding a character fifo in block ram
// depends on s2a_pkg and s2a_ram
`timescale 1ns / 1ps

// usage
//   input channel (i_in_valid / o_in_ready) carries one transaction per item:
//   i_action = 0 delivers the raw set-1 byte on i_scancode, i_action = 1 pops
//   one character. every input transaction yields exactly one output
//   transaction on o_out_valid / i_out_ready with o_read_valid, o_read_char
//   and o_has_char (fifo not empty after this item).
//   shift make codes set the held-shift flag, their break codes clear it;
//   other make codes go through the plain or shifted us table and a nonzero
//   character is written to the fifo, or dropped when DEPTH-1 are stored.
// timing
//   a scancode item or a read on an empty fifo: result registered at the
//   accept edge.
//   a read that pops: the character ram registers the data at the accept
//   edge and the result is registered in the cycle after the accept.
//   a new item is taken only outside the ram data cycle, when the output register
//   is empty or drained in the same cycle, so a stalled receiver holds o_in_ready low.
// reset
//   synchronous, active low: fifo empty, shift released, no result pending.
//   the ram keeps its contents; entries are only read after being written.

module scancode_to_ascii_fifo #(
    parameter int DEPTH = 512
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_action,
    input  logic [7:0] i_scancode,
    // output channel
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_read_valid,
    output logic [6:0] o_read_char,
    output logic       o_has_char
);

    import s2a_pkg::*;

    localparam int PtrW = $clog2(DEPTH);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_RDATA = 2'b10
    } t_state;

    t_state            r_state, n_state;
    logic              r_shift, n_shift;
    logic [PtrW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0]   r_rd_ptr, n_rd_ptr;
    logic              r_out_valid, n_out_valid;
    logic              r_read_valid, n_read_valid;
    logic [CharW-1:0]  r_read_char, n_read_char;
    logic              r_has_char, n_has_char;
    logic              r_pend_has, n_pend_has;

    logic              in_acc;
    logic              out_free;
    logic              fifo_empty;
    logic              fifo_full;
    logic [PtrW-1:0]   wr_ptr_inc;
    logic [PtrW-1:0]   rd_ptr_inc;
    logic [CharW-1:0]  xlat_char;
    logic              ram_we;
    logic              ram_re;
    logic [CharW-1:0]  ram_rdata;

    // pointer successors wrap at DEPTH, which need not be a power of two
    assign wr_ptr_inc = (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + 1'b1;
    assign rd_ptr_inc = (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + 1'b1;
    assign fifo_empty = (r_wr_ptr == r_rd_ptr);
    assign fifo_full  = (wr_ptr_inc == r_rd_ptr);

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && out_free;
    assign in_acc     = i_in_valid && o_in_ready;

    // table lookup on the current shift state; only make codes are written
    assign xlat_char = sc_lookup(i_scancode[6:0], r_shift);

    assign ram_we = in_acc && !i_action && !i_scancode[7] && (xlat_char != '0)
                  && (i_scancode != SC_LSHIFT_MAKE) && (i_scancode != SC_RSHIFT_MAKE)
                  && !fifo_full;
    assign ram_re = in_acc && i_action && !fifo_empty;

    s2a_ram #(
        .WIDTH(CharW),
        .DEPTH(DEPTH)
    ) u_char_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_wr_ptr),
        .i_wdata(xlat_char),
        .i_re   (ram_re),
        .i_raddr(r_rd_ptr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_shift      = r_shift;
        n_wr_ptr     = r_wr_ptr;
        n_rd_ptr     = r_rd_ptr;
        n_out_valid  = r_out_valid;
        n_read_valid = r_read_valid;
        n_read_char  = r_read_char;
        n_has_char   = r_has_char;
        n_pend_has   = r_pend_has;

        // output transaction completes
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (!i_action) begin
                        // scancode item: result is ready right away
                        if (i_scancode == SC_LSHIFT_MAKE || i_scancode == SC_RSHIFT_MAKE) begin
                            n_shift = 1'b1;
                        end else if (i_scancode == SC_LSHIFT_BREAK
                                     || i_scancode == SC_RSHIFT_BREAK) begin
                            n_shift = 1'b0;
                        end
                        if (ram_we) begin
                            n_wr_ptr = wr_ptr_inc;
                        end
                        n_out_valid  = 1'b1;
                        n_read_valid = 1'b0;
                        n_read_char  = '0;
                        n_has_char   = ram_we || !fifo_empty;
                    end else if (fifo_empty) begin
                        // read on empty fifo: nothing changes
                        n_out_valid  = 1'b1;
                        n_read_valid = 1'b0;
                        n_read_char  = '0;
                        n_has_char   = 1'b0;
                    end else begin
                        // pop: wait in ST_RDATA for ram data
                        n_rd_ptr   = rd_ptr_inc;
                        n_pend_has = (r_wr_ptr != rd_ptr_inc);
                        n_state    = ST_RDATA;
                    end
                end
            end
            ST_RDATA: begin
                // output register is free here, the accept required it
                n_out_valid  = 1'b1;
                n_read_valid = 1'b1;
                n_read_char  = ram_rdata;
                n_has_char   = r_pend_has;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_shift     <= 1'b0;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_shift     <= n_shift;
            r_wr_ptr    <= n_wr_ptr;
            r_rd_ptr    <= n_rd_ptr;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_read_valid <= n_read_valid;
        r_read_char  <= n_read_char;
        r_has_char   <= n_has_char;
        r_pend_has   <= n_pend_has;
    end

    assign o_out_valid  = r_out_valid;
    assign o_read_valid = r_read_valid;
    assign o_read_char  = r_read_char;
    assign o_has_char   = r_has_char;

`ifndef SYNTH
    // waiting on ram data never collides with a pending result
    a_rdata_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RDATA) |-> !r_out_valid)
        else $error("ram data cycle with output register occupied");

    // a pop always leads to the ram data cycle
    a_pop_to_rdata: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |=> (r_state == ST_RDATA))
        else $error("pop did not enter ram data cycle");

    // no character reported without a successful pop
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_read_valid) |-> (r_read_char == '0))
        else $error("nonzero character without read_valid");

    // pointers stay inside the ring
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr <= PtrLast) && (r_rd_ptr <= PtrLast))
        else $error("fifo pointer out of range");

    // ram is never written and read in the same cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("ram write and read in the same cycle");
`endif

endmodule

FILE: design/s2a_ram.sv
// s2a_ram: generic single-write, single-read ram with registered read data
// no dependencies; used as the character store of scancode_to_ascii_fifo
`timescale 1ns / 1ps

module s2a_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
